// File: rtl/core/bd_pkg.sv
// Shared types and constants for the bounded deque.
package bd_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned STATUS_W  = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_LIST       = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP_OUT,
    ST_LIST_RD,
    ST_LIST_OUT
  } state_e;

  typedef struct packed {
    logic    accept;
    logic    wr_front;
    logic    wr_rear;
    logic    rd_front;
    logic    rd_rear;
    logic    rd_list;
    logic    idx_inc;
    logic    load_out;
    logic    out_use_ram;
    logic    out_last;
    status_e out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             out_free;
    logic             list_last;
  } dp_stat_t;

endpackage

// File: rtl/core/bd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bd_ram #(
  parameter int unsigned WIDTH = bd_pkg::DATA_W,
  parameter int unsigned DEPTH = bd_pkg::DEPTH_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/bd_ctrl.sv
// Command sequencer for the bounded deque.
module bd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bd_pkg::dp_stat_t  stat_i,
  output bd_pkg::dp_cmd_t   cmd_o
);

  bd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = bd_pkg::ST_EXEC;
        end
      end
      bd_pkg::ST_EXEC: begin
        if (stat_i.out_free) begin
          unique case (stat_i.cmd)
            bd_pkg::CMD_POP_FRONT, bd_pkg::CMD_POP_REAR: begin
              state_d = stat_i.empty ? bd_pkg::ST_IDLE : bd_pkg::ST_POP_OUT;
            end
            bd_pkg::CMD_LIST: begin
              state_d = stat_i.empty ? bd_pkg::ST_IDLE : bd_pkg::ST_LIST_OUT;
            end
            default: begin
              state_d = bd_pkg::ST_IDLE;
            end
          endcase
        end
      end
      bd_pkg::ST_POP_OUT: begin
        if (stat_i.out_free) begin
          state_d = bd_pkg::ST_IDLE;
        end
      end
      bd_pkg::ST_LIST_RD: begin
        state_d = bd_pkg::ST_LIST_OUT;
      end
      bd_pkg::ST_LIST_OUT: begin
        if (stat_i.out_free) begin
          state_d = stat_i.list_last ? bd_pkg::ST_IDLE : bd_pkg::ST_LIST_RD;
        end
      end
      default: begin
        state_d = bd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.out_status = bd_pkg::STATUS_DONE;
    in_ready_o       = 1'b0;
    unique case (state_q)
      bd_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      bd_pkg::ST_EXEC: begin
        if (stat_i.out_free) begin
          unique case (stat_i.cmd)
            bd_pkg::CMD_PUSH_FRONT, bd_pkg::CMD_PUSH_REAR: begin
              cmd_o.load_out = 1'b1;
              cmd_o.out_last = 1'b1;
              if (stat_i.full) begin
                cmd_o.out_status = bd_pkg::STATUS_FULL;
              end else begin
                cmd_o.wr_front = (stat_i.cmd == bd_pkg::CMD_PUSH_FRONT);
                cmd_o.wr_rear  = (stat_i.cmd == bd_pkg::CMD_PUSH_REAR);
              end
            end
            bd_pkg::CMD_POP_FRONT, bd_pkg::CMD_POP_REAR, bd_pkg::CMD_LIST: begin
              if (stat_i.empty) begin
                cmd_o.load_out   = 1'b1;
                cmd_o.out_last   = 1'b1;
                cmd_o.out_status = bd_pkg::STATUS_EMPTY;
              end else begin
                cmd_o.rd_front = (stat_i.cmd == bd_pkg::CMD_POP_FRONT);
                cmd_o.rd_rear  = (stat_i.cmd == bd_pkg::CMD_POP_REAR);
                cmd_o.rd_list  = (stat_i.cmd == bd_pkg::CMD_LIST);
              end
            end
            default: begin
              cmd_o.load_out = 1'b0;
            end
          endcase
        end
      end
      bd_pkg::ST_POP_OUT: begin
        cmd_o.load_out    = stat_i.out_free;
        cmd_o.out_use_ram = 1'b1;
        cmd_o.out_last    = 1'b1;
      end
      bd_pkg::ST_LIST_RD: begin
        cmd_o.rd_list = 1'b1;
      end
      bd_pkg::ST_LIST_OUT: begin
        cmd_o.load_out    = stat_i.out_free;
        cmd_o.idx_inc     = stat_i.out_free;
        cmd_o.out_use_ram = 1'b1;
        cmd_o.out_last    = stat_i.list_last;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/core/bd_datapath.sv
// Pointers, count, capacity register, entry store and output register of the deque.
module bd_datapath #(
  parameter int unsigned DEPTH = bd_pkg::DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [bd_pkg::CAP_W-1:0]        cfg_data_i,
  input  logic [bd_pkg::CMD_W-1:0]        in_cmd_i,
  input  logic signed [bd_pkg::DATA_W-1:0] in_value_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [bd_pkg::STATUS_W-1:0]     out_status_o,
  output logic signed [bd_pkg::DATA_W-1:0] out_item_o,
  output logic                            out_last_o,
  input  bd_pkg::dp_cmd_t                 cmd_i,
  output bd_pkg::dp_stat_t                stat_o
);

  localparam int unsigned IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > bd_pkg::CAP_W) ? CW : bd_pkg::CAP_W;

  logic [bd_pkg::CAP_W-1:0]        cap_q;
  logic [bd_pkg::CMD_W-1:0]        cmd_q;
  logic signed [bd_pkg::DATA_W-1:0] value_q;
  logic [IW-1:0]                   head_q, head_d;
  logic [CW-1:0]                   count_q, count_d;
  logic [CW-1:0]                   idx_q, idx_d;
  logic                            out_valid_q, out_valid_d;
  logic [bd_pkg::STATUS_W-1:0]     out_status_q;
  logic signed [bd_pkg::DATA_W-1:0] out_item_q;
  logic                            out_last_q;

  logic [IW-1:0]                   head_dec;
  logic [IW-1:0]                   head_inc;
  logic [IW-1:0]                   rd_addr;
  logic [IW-1:0]                   wr_addr;
  logic                            wr_en;
  logic                            rd_en;
  logic [bd_pkg::DATA_W-1:0]       rd_data;
  logic                            out_free;

  function automatic logic [IW-1:0] wrap_slot(input logic [IW-1:0] base,
                                              input logic [CW-1:0] offset);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(offset);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  assign head_dec = (head_q == '0) ? IW'(DEPTH - 1) : head_q - IW'(1);
  assign head_inc = wrap_slot(head_q, CW'(1));

  always_comb begin
    priority if (cmd_i.rd_front) begin
      rd_addr = head_q;
    end else if (cmd_i.rd_rear) begin
      rd_addr = wrap_slot(head_q, count_q - CW'(1));
    end else begin
      rd_addr = wrap_slot(head_q, idx_q);
    end
  end

  assign wr_addr = cmd_i.wr_front ? head_dec : wrap_slot(head_q, count_q);
  assign wr_en   = cmd_i.wr_front | cmd_i.wr_rear;
  assign rd_en   = cmd_i.rd_front | cmd_i.rd_rear | cmd_i.rd_list;

  bd_ram #(
    .WIDTH (bd_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (value_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    priority if (cmd_i.wr_front) begin
      head_d  = head_dec;
      count_d = count_q + CW'(1);
    end else if (cmd_i.wr_rear) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.rd_front) begin
      head_d  = head_inc;
      count_d = count_q - CW'(1);
    end else if (cmd_i.rd_rear) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    priority if (cmd_i.accept) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + CW'(1);
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= bd_pkg::CAP_RESET;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      head_q      <= head_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q   <= in_cmd_i;
      value_q <= in_value_i;
    end
    if (cmd_i.load_out) begin
      out_status_q <= cmd_i.out_status;
      out_item_q   <= cmd_i.out_use_ram ? rd_data : '0;
      out_last_q   <= cmd_i.out_last;
    end
  end

  assign stat_o.cmd       = cmd_q;
  assign stat_o.full      = (CMPW'(count_q) >= CMPW'(cap_q)) || (count_q == CW'(DEPTH));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.out_free  = out_free;
  assign stat_o.list_last = ((idx_q + CW'(1)) == count_q);

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_item_o   = out_item_q;
  assign out_last_o   = out_last_q;

endmodule

// File: rtl/core/bounded_deque.sv
// Top level of the bounded double-ended queue.
// Input channel (s_axis): tuser carries the command (push front, push rear,
// pop front, pop rear, list), tdata the signed 32-bit value to push.
// Output channel (m_axis): tuser carries the status (done, full, empty),
// tdata the popped or listed entry (zero after a push or a refusal), and
// tlast marks the final item caused by a command.
// Configuration channel (cfg): writes the capacity limit, clamped to DEPTH.
// Write it only while no command is in flight.
// Timing: one command at a time. A push or a refused command has its result
// loaded from the execute state; a pop reads its entry, then loads it.
// A list yields one item per entry, reading and loading them in turn, as the
// entry store has a registered read port. The next command can be accepted
// in the cycle after the last result is loaded into the output register.
// Reset empties the deque, sets the head to slot 0 and the capacity to 16;
// the store contents are not cleared. When the receiver stalls, the output
// register holds its item and the sequencer waits before loading the next.
module bounded_deque #(
  parameter int unsigned DEPTH = bd_pkg::DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bd_pkg::CAP_W-1:0]         cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic signed [bd_pkg::DATA_W-1:0] s_axis_tdata,   // [31:0] value
  input  logic [bd_pkg::CMD_W-1:0]         s_axis_tuser,   // [2:0] command
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic signed [bd_pkg::DATA_W-1:0] m_axis_tdata,   // [31:0] item
  output logic [bd_pkg::STATUS_W-1:0]      m_axis_tuser,   // [1:0] status
  output logic                             m_axis_tlast
);

  bd_pkg::dp_cmd_t  dp_cmd;
  bd_pkg::dp_stat_t dp_stat;

  assign cfg_ready_o = 1'b1;

  bd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  bd_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_cmd_i     (s_axis_tuser),
    .in_value_i   (s_axis_tdata),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_item_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat)
  );

endmodule

// File: bench/bd_checker.sv
// Checker for the bounded deque: predicts every reply from observed handshakes and compares.
`timescale 1ns / 1ps
module bd_checker
  import bd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CAP_W-1:0]      cfg_data_i,
  input  logic                  s_valid_i,
  input  logic                  s_ready_i,
  input  logic [DATA_W-1:0]     s_data_i,
  input  logic [CMD_W-1:0]      s_user_i,
  input  logic                  m_valid_i,
  input  logic                  m_ready_i,
  input  logic [DATA_W-1:0]     m_data_i,
  input  logic [STATUS_W-1:0]   m_user_i,
  input  logic                  m_last_i,
  output int                    pending_o,
  output int                    err_count_o
);

  localparam int unsigned SLOT_W = $clog2(DEPTH_DEF);

  typedef struct {
    status_e           status;
    logic [DATA_W-1:0] item;
    logic              last;
  } reply_t;

  reply_t             deque_replies[$];
  logic [DATA_W-1:0]  deque_mem [DEPTH_DEF];
  logic [SLOT_W-1:0]  front_slot;
  logic [CAP_W-1:0]   live_count;
  logic [CAP_W-1:0]   cap_reg;
  int                 errors = 0;

  assign err_count_o = errors;

  task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  task automatic run_deque_cmd(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val);
    logic [CAP_W-1:0]  limit;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] popped;
    limit = (cap_reg > DEPTH_DEF) ? CAP_W'(DEPTH_DEF) : cap_reg;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (live_count >= limit) begin
          deque_replies.push_back('{STATUS_FULL, '0, 1'b1});
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            front_slot = front_slot - 1'b1;
            deque_mem[front_slot] = val;
          end else begin
            slot = front_slot + live_count[SLOT_W-1:0];
            deque_mem[slot] = val;
          end
          live_count++;
          deque_replies.push_back('{STATUS_DONE, '0, 1'b1});
        end
      end
      CMD_POP_FRONT: begin
        if (live_count == 0) begin
          deque_replies.push_back('{STATUS_EMPTY, '0, 1'b1});
        end else begin
          popped = deque_mem[front_slot];
          front_slot = front_slot + 1'b1;
          live_count--;
          deque_replies.push_back('{STATUS_DONE, popped, 1'b1});
        end
      end
      CMD_POP_REAR: begin
        if (live_count == 0) begin
          deque_replies.push_back('{STATUS_EMPTY, '0, 1'b1});
        end else begin
          live_count--;
          slot = front_slot + live_count[SLOT_W-1:0];
          deque_replies.push_back('{STATUS_DONE, deque_mem[slot], 1'b1});
        end
      end
      CMD_LIST: begin
        if (live_count == 0) begin
          deque_replies.push_back('{STATUS_EMPTY, '0, 1'b1});
        end else begin
          for (int i = 0; i < live_count; i++) begin
            slot = front_slot + SLOT_W'(i);
            deque_replies.push_back('{STATUS_DONE, deque_mem[slot], (i + 1 == live_count)});
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      deque_replies.delete();
      front_slot = '0;
      live_count = '0;
      cap_reg    = CAP_RESET;
      pending_o <= 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (deque_replies.size() == 0) begin
          report_mismatch("unexpected item", m_data_i, '0);
        end else begin
          want = deque_replies.pop_front();
          if (m_user_i !== want.status)
            report_mismatch("status", DATA_W'(m_user_i), DATA_W'(want.status));
          if (m_data_i !== want.item) report_mismatch("item", m_data_i, want.item);
          if (m_last_i !== want.last)
            report_mismatch("last", DATA_W'(m_last_i), DATA_W'(want.last));
        end
      end
      if (cfg_valid_i && cfg_ready_i) cap_reg = cfg_data_i;
      if (s_valid_i && s_ready_i) run_deque_cmd(s_user_i, s_data_i);
      pending_o <= deque_replies.size();
    end
  end

endmodule

// File: bench/tb_bounded_deque.sv
// Testbench top for the bounded deque: stimulus, flow control, watchdog and verdict.
`timescale 1ns / 1ps
module tb_bounded_deque;
  import bd_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
  localparam logic [CAP_W-1:0] CAP_NONE = 5'd0;
  localparam logic [CAP_W-1:0] CAP_MAX  = 5'd31;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CAP_W-1:0]    cfg_data  = '0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [DATA_W-1:0]   s_tdata   = '0;
  logic [CMD_W-1:0]    s_tuser   = '0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [DATA_W-1:0]   m_tdata;
  logic [STATUS_W-1:0] m_tuser;
  logic                m_tlast;
  logic                quiet      = 1'b0;
  int                  hold_count = 0;
  int                  pending;
  int                  errors;

  bounded_deque DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  bd_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .s_valid_i   (s_tvalid),
    .s_ready_i   (s_tready),
    .s_data_i    (s_tdata),
    .s_user_i    (s_tuser),
    .m_valid_i   (m_tvalid),
    .m_ready_i   (m_tready),
    .m_data_i    (m_tdata),
    .m_user_i    (m_tuser),
    .m_last_i    (m_tlast),
    .pending_o   (pending),
    .err_count_o (errors)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] rand_cmd(input bit fill);
    int unsigned r;
    r = $urandom_range(99);
    if (r < (fill ? 55 : 25)) return $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
    if (r < 80) return $urandom_range(1) ? CMD_POP_REAR : CMD_POP_FRONT;
    if (r < 95) return CMD_LIST;
    return CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val);
    while (!quiet && $urandom_range(99) < 16) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= val;
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cap(input logic [CAP_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : sink
    int seen;
    int stall_left;
    seen       = 0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_count != seen) begin
        seen       = hold_count;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (quiet) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 16);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    logic [CAP_W-1:0] phase_caps [7];
    phase_caps = '{CAP_MAX, 5'd1, 5'd16, 5'd5, CAP_NONE, 5'd17, 5'd16};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(CMD_POP_FRONT, rand_value());
    send_cmd(CMD_POP_REAR, rand_value());
    send_cmd(CMD_LIST, rand_value());
    send_cmd(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
    send_cmd(CMD_PUSH_REAR, 32'h8000_0000);
    send_cmd(CMD_PUSH_FRONT, 32'h0000_0000);
    send_cmd(CMD_PUSH_REAR, 32'hFFFF_FFFF);
    send_cmd(CMD_PUSH_FRONT, 32'h5555_5555);
    send_cmd(CMD_PUSH_REAR, 32'hAAAA_AAAA);
    send_cmd(CMD_LIST, '0);
    send_cmd(CMD_POP_FRONT, '0);
    send_cmd(CMD_POP_REAR, '0);
    send_cmd(CMD_SPARE_FIRST, rand_value());
    send_cmd(CMD_SPARE_FIRST + 1'b1, rand_value());
    send_cmd(CMD_SPARE_LAST, rand_value());
    drain();

    // shrink below the current fill
    write_cap(5'd2);
    send_cmd(CMD_PUSH_REAR, rand_value());
    send_cmd(CMD_POP_FRONT, '0);
    send_cmd(CMD_POP_REAR, '0);
    send_cmd(CMD_PUSH_FRONT, rand_value());
    send_cmd(CMD_POP_REAR, '0);
    send_cmd(CMD_PUSH_FRONT, rand_value());
    send_cmd(CMD_LIST, '0);
    drain();

    write_cap(CAP_NONE);
    send_cmd(CMD_PUSH_REAR, rand_value());
    send_cmd(CMD_POP_FRONT, '0);
    send_cmd(CMD_POP_REAR, '0);
    drain();

    for (int p = 0; p < 7; p++) begin
      write_cap(phase_caps[p]);
      quiet <= (p == 3);
      for (int n = 0; n < 7; n++) send_cmd(rand_cmd(p % 2 == 0), rand_value());
      drain();
      if (p == 2) begin
        // fill to the limit, then stall the output while commands keep coming
        repeat (18) send_cmd($urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT, rand_value());
        hold_count <= hold_count + 1;
        send_cmd(CMD_LIST, rand_value());
        repeat (4) send_cmd(rand_cmd(1'b0), rand_value());
        drain();
      end
    end
    write_cap(CAP_W'($urandom_range(16, 1)));
    for (int n = 0; n < 12; n++) send_cmd(rand_cmd($urandom_range(1) != 0), rand_value());
    drain();

    repeat (20) @(posedge clk_i);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/bd_pkg.sv
rtl/core/bd_ram.sv
rtl/core/bd_ctrl.sv
rtl/core/bd_datapath.sv
rtl/core/bounded_deque.sv
bench/bd_checker.sv
bench/tb_bounded_deque.sv
